FILE: rtl/rtprt_pkg.sv
// Package for the RTP packet receive tracker.
// Holds the sequence limits, status codes and register indexes.
// No dependencies.
package rtprt_pkg;

  localparam logic [15:0] DROPOUT_LIMIT  = 16'd3000;
  localparam logic [15:0] MISORDER_EDGE  = 16'd65435;  // 65535 minus the misorder limit
  localparam logic [7:0]  LATE_LIMIT     = 8'd200;
  localparam logic [7:0]  LATE_RUN_MAX   = 8'd255;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_MISORDER  = 2'd1;
  localparam status_t STATUS_LATE      = 2'd2;
  localparam status_t STATUS_SKEW      = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SKEW_THRESHOLD = 2'd0;
  localparam reg_idx_t REG_QUEUE_PACKETS  = 2'd1;
  localparam reg_idx_t REG_FRAME_SAMPLES  = 2'd2;

  localparam logic [15:0] SKEW_THRESHOLD_RST = 16'd256;
  localparam logic [7:0]  QUEUE_PACKETS_RST  = 8'd4;
  localparam logic [13:0] FRAME_SAMPLES_RST  = 14'd256;

endpackage

FILE: rtl/rtp_packet_receive_tracker.sv
// RTP packet receive tracker: sequence tracking, skew smoothing, jitter and playout.
// Depends on rtprt_pkg.
//
// Usage: one word on the input channel is one RTP header (sequence number,
// media timestamp, arrival time) plus the current playout time. Each word
// yields exactly one result word with a status, the extended sequence number,
// the playout time, the skew correction, the jitter estimate, the highest
// extended sequence number and a resync flag.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// A word accepted is held in the input register, processed from there and
// registered into the result register once the result stage is free.
// While the receiver does not stall, one word per cycle is sustained; the
// input register and the result register are parted so that a new word is
// taken while a finished result still waits. The per-word update of the
// tracking state is combinational add, compare and shift logic, which sets
// the one-word-per-cycle rate.
// When the receiver stalls, the result holds; the input register still fills
// once, then in_stall rises until the result is taken.
// Reset clears both stages, returns the registers to their defaults and puts
// the tracker in the need-sync state, so the first packet resyncs.
// Registers (APB, byte address 4*i): skew_threshold, queue_packets,
// frame_samples. Write them only while the block is idle.
module rtp_packet_receive_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_seq_num,
  input  logic [31:0] in_rtp_timestamp,
  input  logic [31:0] in_arrival_time,
  input  logic [31:0] in_playtime_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_extended_seq,
  output logic [31:0] out_playout_time,
  output logic signed [16:0] out_clock_adjust,
  output logic signed [31:0] out_jitter_estimate,
  output logic [31:0] out_max_extended,
  output logic        out_resynced,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [15:0] skew_thr_r;
  logic [7:0]  queue_pkts_r;
  logic [13:0] frame_smp_r;
  logic [21:0] fixed_delay_r;
  logic        cfg_wr;
  rtprt_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    case (cfg_idx)
      rtprt_pkg::REG_SKEW_THRESHOLD: prdata = {16'd0, skew_thr_r};
      rtprt_pkg::REG_QUEUE_PACKETS:  prdata = {24'd0, queue_pkts_r};
      rtprt_pkg::REG_FRAME_SAMPLES:  prdata = {18'd0, frame_smp_r};
      default:                       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skew_thr_r   <= rtprt_pkg::SKEW_THRESHOLD_RST;
      queue_pkts_r <= rtprt_pkg::QUEUE_PACKETS_RST;
      frame_smp_r  <= rtprt_pkg::FRAME_SAMPLES_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rtprt_pkg::REG_SKEW_THRESHOLD: skew_thr_r   <= pwdata[15:0];
        rtprt_pkg::REG_QUEUE_PACKETS:  queue_pkts_r <= pwdata[7:0];
        rtprt_pkg::REG_FRAME_SAMPLES:  frame_smp_r  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // The fixed playout delay only changes with the registers, so it is kept ready.
  always_ff @(posedge clk) begin
    fixed_delay_r <= queue_pkts_r * frame_smp_r;
  end

  // Input register.
  logic        s1_valid_r;
  logic [15:0] s1_seq_r;
  logic [31:0] s1_ts_r;
  logic [31:0] s1_arr_r;
  logic [31:0] s1_now_r;
  logic        adv;
  logic        in_take;

  assign adv      = s1_valid_r & (~out_valid | ~out_stall);
  assign in_stall = s1_valid_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_seq_r <= in_seq_num;
      s1_ts_r  <= in_rtp_timestamp;
      s1_arr_r <= in_arrival_time;
      s1_now_r <= in_playtime_now;
    end
  end

  // Tracking state.
  logic        need_sync_r,  need_sync_nxt;
  logic [15:0] highest_r,    highest_nxt;
  logic [15:0] wrap_r,       wrap_nxt;
  logic [16:0] bad_seq_r,    bad_seq_nxt;
  logic [31:0] ts_offset_r,  ts_offset_nxt;
  logic        skew_first_r, skew_first_nxt;
  logic [31:0] delay_est_r,  delay_est_nxt;
  logic [31:0] active_r,     active_nxt;
  logic        jit_first_r,  jit_first_nxt;
  logic [31:0] prev_tr_r,    prev_tr_nxt;
  logic [31:0] jitter_r,     jitter_nxt;
  logic [7:0]  late_run_r,   late_run_nxt;
  logic [31:0] max_ext_r,    max_ext_nxt;

  // Result values.
  rtprt_pkg::status_t res_status;
  logic [31:0] res_ext;
  logic [31:0] res_playout;
  logic [16:0] res_adj;
  logic        res_resync;

  // Working values.
  logic [31:0] cur_off, min_off, off1, base, diff, d_tr, absd, s2, s2b, d3, pl_minus_now;
  logic [15:0] udelta;
  logic        init, drop, wrap_inc;
  logic        sf_eff, jf_eff;
  logic [31:0] de_eff, act_eff, jv_eff, prev_eff, de_new, adj32, playout;
  logic [36:0] de_sum;
  logic [32:0] diff33, thr33, nthr33;
  logic        skew_dn, skew_up;
  logic [7:0]  lr_inc;

  always_comb begin
    need_sync_nxt  = need_sync_r;
    highest_nxt    = highest_r;
    wrap_nxt       = wrap_r;
    bad_seq_nxt    = bad_seq_r;
    skew_first_nxt = skew_first_r;
    delay_est_nxt  = delay_est_r;
    active_nxt     = active_r;
    jit_first_nxt  = jit_first_r;
    prev_tr_nxt    = prev_tr_r;
    jitter_nxt     = jitter_r;
    late_run_nxt   = late_run_r;
    max_ext_nxt    = max_ext_r;
    init     = 1'b0;
    drop     = 1'b0;
    wrap_inc = 1'b0;

    cur_off = s1_arr_r - s1_ts_r;
    diff    = cur_off - ts_offset_r;
    min_off = diff[31] ? cur_off : ts_offset_r;
    udelta  = s1_seq_r - highest_r;

    // Sequence tracking.
    if (need_sync_r) begin
      init = 1'b1;
      need_sync_nxt = 1'b0;
    end else if (udelta < rtprt_pkg::DROPOUT_LIMIT) begin
      wrap_inc = (s1_seq_r < highest_r);
    end else if (udelta <= rtprt_pkg::MISORDER_EDGE) begin
      if ({1'b0, s1_seq_r} == bad_seq_r) begin
        init = 1'b1;
      end else begin
        drop = 1'b1;
        bad_seq_nxt = {1'b0, s1_seq_r} + 17'd1;
      end
    end

    // Statistics as seen after a possible restart.
    off1    = init ? cur_off : min_off;
    sf_eff  = init | skew_first_r;
    jf_eff  = init | jit_first_r;
    de_eff  = init ? 32'd0 : delay_est_r;
    act_eff = init ? 32'd0 : active_r;
    jv_eff  = init ? 32'd0 : jitter_r;
    prev_eff = jf_eff ? cur_off : prev_tr_r;

    if (init) begin
      highest_nxt = s1_seq_r;
      wrap_nxt    = 16'd0;
    end else if (!drop && udelta < rtprt_pkg::DROPOUT_LIMIT) begin
      highest_nxt = s1_seq_r;
      wrap_nxt    = wrap_r + {15'd0, wrap_inc};
    end

    res_ext = {wrap_nxt, s1_seq_r};
    if (init) begin
      max_ext_nxt = {16'd0, s1_seq_r};
    end else if (!drop && res_ext > max_ext_r) begin
      max_ext_nxt = res_ext;
    end
    base = s1_ts_r + off1;

    // Skew smoothing: floor((31*est + delay) / 32).
    de_sum = {de_eff, 5'd0} - {5'd0, de_eff} + {5'd0, cur_off};
    de_new = de_sum[36:5];
    diff33 = {1'b0, act_eff} - {1'b0, de_new};
    diff33 = {diff33[31], diff33[31:0]};
    thr33  = {17'd0, skew_thr_r};
    nthr33 = 33'd0 - thr33;
    skew_dn = ~sf_eff & ($signed(diff33) >= $signed(thr33));
    skew_up = ~sf_eff & ~skew_dn & ($signed(diff33) <= $signed(nthr33));
    ts_offset_nxt = off1;
    if (sf_eff) begin
      skew_first_nxt = 1'b0;
      delay_est_nxt  = cur_off;
      active_nxt     = cur_off;
      adj32          = 32'd0;
    end else begin
      delay_est_nxt = de_new;
      active_nxt    = act_eff;
      adj32         = 32'd0;
      if (skew_dn) begin
        ts_offset_nxt = off1 - {16'd0, skew_thr_r};
        active_nxt    = de_new;
        adj32         = 32'd0 - {16'd0, skew_thr_r};
      end else if (skew_up) begin
        ts_offset_nxt = off1 + {16'd0, skew_thr_r};
        active_nxt    = de_new;
        adj32         = {16'd0, skew_thr_r};
      end
    end

    // Jitter: est += (|d| - est) / 16, truncated toward zero.
    d_tr = prev_eff - cur_off;
    absd = d_tr[31] ? (32'd0 - d_tr) : d_tr;
    s2   = absd - jv_eff;
    s2b  = s2 + (s2[31] ? 32'd15 : 32'd0);
    d3   = {{4{s2b[31]}}, s2b[31:4]};
    jitter_nxt    = jv_eff + d3;
    prev_tr_nxt   = cur_off;
    jit_first_nxt = 1'b0;

    // Playout and the late check.
    playout      = base + adj32 + {10'd0, fixed_delay_r};
    pl_minus_now = playout - s1_now_r;
    lr_inc       = (late_run_r == rtprt_pkg::LATE_RUN_MAX) ? late_run_r : late_run_r + 8'd1;
    res_adj      = adj32[16:0];
    res_playout  = playout;
    res_resync   = init;
    if (pl_minus_now[31]) begin
      late_run_nxt = lr_inc;
      if (lr_inc > rtprt_pkg::LATE_LIMIT) begin
        need_sync_nxt = 1'b1;
      end
      res_status = rtprt_pkg::STATUS_LATE;
    end else begin
      late_run_nxt = 8'd0;
      res_status = (skew_dn && skew_thr_r != 16'd0) ? rtprt_pkg::STATUS_SKEW
                                                    : rtprt_pkg::STATUS_OK;
    end

    // A misordered word touches only the offset minimum and the expected jump.
    if (drop) begin
      highest_nxt    = highest_r;
      wrap_nxt       = wrap_r;
      max_ext_nxt    = max_ext_r;
      ts_offset_nxt  = min_off;
      skew_first_nxt = skew_first_r;
      delay_est_nxt  = delay_est_r;
      active_nxt     = active_r;
      jit_first_nxt  = jit_first_r;
      prev_tr_nxt    = prev_tr_r;
      jitter_nxt     = jitter_r;
      late_run_nxt   = late_run_r;
      need_sync_nxt  = need_sync_r;
      res_status     = rtprt_pkg::STATUS_MISORDER;
      res_ext        = 32'd0;
      res_playout    = 32'd0;
      res_adj        = 17'd0;
      res_resync     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_sync_r  <= 1'b1;
      highest_r    <= 16'd0;
      wrap_r       <= 16'd0;
      bad_seq_r    <= 17'd1;
      ts_offset_r  <= 32'd0;
      skew_first_r <= 1'b1;
      delay_est_r  <= 32'd0;
      active_r     <= 32'd0;
      jit_first_r  <= 1'b1;
      prev_tr_r    <= 32'd0;
      jitter_r     <= 32'd0;
      late_run_r   <= 8'd0;
      max_ext_r    <= 32'd0;
    end else if (adv) begin
      need_sync_r  <= need_sync_nxt;
      highest_r    <= highest_nxt;
      wrap_r       <= wrap_nxt;
      bad_seq_r    <= bad_seq_nxt;
      ts_offset_r  <= ts_offset_nxt;
      skew_first_r <= skew_first_nxt;
      delay_est_r  <= delay_est_nxt;
      active_r     <= active_nxt;
      jit_first_r  <= jit_first_nxt;
      prev_tr_r    <= prev_tr_nxt;
      jitter_r     <= jitter_nxt;
      late_run_r   <= late_run_nxt;
      max_ext_r    <= max_ext_nxt;
    end
  end

  // Result register.
  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status          <= res_status;
      out_extended_seq    <= res_ext;
      out_playout_time    <= res_playout;
      out_clock_adjust    <= $signed(res_adj);
      out_jitter_estimate <= $signed(jitter_nxt);
      out_max_extended    <= max_ext_nxt;
      out_resynced        <= res_resync;
    end
  end

endmodule

FILE: rtl/rtprt_checker.sv
// Port-level checker for the RTP packet receive tracker, bound to its top level.
// Depends on rtprt_pkg and rtp_packet_receive_tracker.
module rtprt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_extended_seq,
  input logic [31:0] out_playout_time,
  input logic signed [16:0] out_clock_adjust,
  input logic [31:0] out_max_extended,
  input logic        out_resynced
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_extended_seq)
      && $stable(out_status) && $stable(out_playout_time))
    else $error("result word changed while stalled");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A misordered drop carries no sequence, playout or adjustment and no resync.
  a_misorder_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rtprt_pkg::STATUS_MISORDER |->
      out_extended_seq == 32'd0 && out_playout_time == 32'd0
      && out_clock_adjust == 17'sd0 && !out_resynced)
    else $error("misordered drop with nonzero fields");

  // After a resync the wrap count restarts and the maximum is this packet.
  a_resync_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resynced |->
      out_max_extended == out_extended_seq && out_extended_seq[31:16] == 16'd0)
    else $error("resync did not restart sequence statistics");

  // A skew drop only follows a negative clock adjustment.
  a_skew_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rtprt_pkg::STATUS_SKEW |-> out_clock_adjust < 17'sd0)
    else $error("skew drop without negative adjustment");

endmodule

bind rtp_packet_receive_tracker rtprt_checker u_rtprt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_extended_seq (out_extended_seq),
  .out_playout_time (out_playout_time),
  .out_clock_adjust (out_clock_adjust),
  .out_max_extended (out_max_extended),
  .out_resynced     (out_resynced)
);
